[rtl/core/assert_macros.svh]
// Concurrent assertion helpers, sampled on the rising clock edge and
// disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that cond at one edge implies nxt at the following edge.
`define ASSERT_NEXT(label, cond, nxt, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);

`endif

[rtl/core/dngd_pkg.sv]
package dngd_pkg;

   localparam int MAX_N     = 31;
   localparam int MAX_M     = 31;
   localparam int CELL_W    = 64;
   localparam int DIM_W     = 5;
   localparam int COL_COUNT = MAX_M + 1;
   localparam int COL_W     = $clog2(COL_COUNT);
   // last-row tokens of up to ten earlier words can still be in the chain
   localparam int TAG_W     = 4;

   localparam logic [DIM_W-1:0]  MAX_N_DIM = DIM_W'(MAX_N);
   localparam logic [DIM_W-1:0]  MAX_M_DIM = DIM_W'(MAX_M);
   localparam logic [CELL_W-1:0] ONE_CELL  = CELL_W'(1);

   typedef struct packed {
      logic             valid;
      logic             first_row;
      logic             last_row;
      logic [TAG_W-1:0] tag;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ISSUE,
      SEQ_WAIT
   } seq_state_type;

endpackage

[rtl/core/delannoy_number_grid_dp.sv]
// One word at a time: a start is taken only while busy is low, and busy stays high
// until the result strobe, which waits for the skewed wavefront of the last row to
// reach column m in the 32-cell column chain.
// Reset: synchronous, active high; clears the sequencer, the cell tokens and the strobe.
// The result strobe lasts one cycle and the receiver cannot stall it.
`include "assert_macros.svh"

module delannoy_number_grid_dp
   import dngd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [DIM_W-1:0]  req_rows_n,
   input  logic [DIM_W-1:0]  req_cols_m,
   output logic              rsp_valid,
   output logic [CELL_W-1:0] rsp_delannoy_value,
   output logic              rsp_overflowed
);

   cell_ctrl_type     token;
   logic [COL_W-1:0]  col_sel;
   logic [TAG_W-1:0]  tag;
   logic              done;
   cell_ctrl_type     sel_ctrl;

   cell_ctrl_type     cell_ctrl [COL_COUNT];
   logic [CELL_W-1:0] cell_val  [COL_COUNT];
   logic [CELL_W-1:0] cell_prev [COL_COUNT];
   logic              cell_ovf  [COL_COUNT];

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CELL_W-1:0] rsp_value_ff;
   logic              rsp_ovf_ff;

   dngd_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .rows_n  (req_rows_n),
      .cols_m  (req_cols_m),
      .done    (done),
      .busy    (busy),
      .token   (token),
      .col_sel (col_sel),
      .tag     (tag)
   );

   for (genvar g = 0; g < COL_COUNT; g++) begin : g_col
      if (g == 0) begin : g_head
         dngd_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .left_ctrl (token),
            .left_val  ('0),
            .left_prev ('0),
            .left_ovf  (1'b0),
            .ctrl_out  (cell_ctrl[g]),
            .val_out   (cell_val[g]),
            .prev_out  (cell_prev[g]),
            .ovf_out   (cell_ovf[g])
         );
      end else begin : g_body
         dngd_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .left_ctrl (cell_ctrl[g-1]),
            .left_val  (cell_val[g-1]),
            .left_prev (cell_prev[g-1]),
            .left_ovf  (cell_ovf[g-1]),
            .ctrl_out  (cell_ctrl[g]),
            .val_out   (cell_val[g]),
            .prev_out  (cell_prev[g]),
            .ovf_out   (cell_ovf[g])
         );
      end
   end

   // last row reaching column m, tagged with the current request
   assign sel_ctrl     = cell_ctrl[col_sel];
   assign done         = busy && sel_ctrl.valid && sel_ctrl.last_row && (sel_ctrl.tag == tag);
   assign rsp_valid_in = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_value_ff <= cell_val[col_sel];
         rsp_ovf_ff   <= cell_ovf[col_sel];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_delannoy_value = rsp_value_ff;
   assign rsp_overflowed     = rsp_ovf_ff;

   `ASSERT_NEXT(a_one_result, rsp_valid_ff, !rsp_valid_ff, "result strobe longer than one cycle")
   `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word without busy")
   `ASSERT_CLK(a_ovf_saturates, !(rsp_valid_ff && rsp_ovf_ff) || (&rsp_value_ff),
               "overflow without saturated value")

endmodule

[rtl/core/dngd_cell.sv]
module dngd_cell
   import dngd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     left_ctrl,
   input  logic [CELL_W-1:0] left_val,
   input  logic [CELL_W-1:0] left_prev,
   input  logic              left_ovf,
   output cell_ctrl_type     ctrl_out,
   output logic [CELL_W-1:0] val_out,
   output logic [CELL_W-1:0] prev_out,
   output logic              ovf_out
);

   cell_ctrl_type     ctrl_ff;
   logic [CELL_W-1:0] val_ff;
   logic [CELL_W-1:0] val_in;
   logic [CELL_W-1:0] prev_ff;
   logic              ovf_ff;
   logic              ovf_in;
   logic [CELL_W+1:0] sum;

   // up = own latest value, upper-left = neighbor's previous, left = neighbor's latest
   assign sum = {2'b00, val_ff} + {2'b00, left_prev} + {2'b00, left_val};

   always_comb begin
      if (left_ctrl.first_row) begin
         val_in = ONE_CELL;
         ovf_in = 1'b0;
      end else if (|sum[CELL_W+1:CELL_W]) begin
         val_in = '1;
         ovf_in = 1'b1;
      end else begin
         val_in = sum[CELL_W-1:0];
         ovf_in = ovf_ff | left_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= left_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (left_ctrl.valid) begin
         prev_ff <= val_ff;
         val_ff  <= val_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign val_out  = val_ff;
   assign prev_out = prev_ff;
   assign ovf_out  = ovf_ff;

endmodule

[rtl/core/dngd_seq.sv]
`include "assert_macros.svh"

module dngd_seq
   import dngd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIM_W-1:0] rows_n,
   input  logic [DIM_W-1:0] cols_m,
   input  logic             done,
   output logic             busy,
   output cell_ctrl_type    token,
   output logic [COL_W-1:0] col_sel,
   output logic [TAG_W-1:0] tag
);

   seq_state_type    state_ff;
   seq_state_type    state_in;
   logic [DIM_W-1:0] row_ff;
   logic [DIM_W-1:0] row_in;
   logic [DIM_W-1:0] n_ff;
   logic [DIM_W-1:0] m_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [TAG_W-1:0] tag_in;
   logic             accept;

   assign accept = start && (state_ff == SEQ_IDLE);

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      tag_in   = tag_ff;
      token    = '0;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_ISSUE;
               row_in   = '0;
               tag_in   = tag_ff + TAG_W'(1);
            end
         end
         SEQ_ISSUE: begin
            token.valid     = 1'b1;
            token.first_row = (row_ff == '0);
            token.last_row  = (row_ff == n_ff);
            token.tag       = tag_ff;
            row_in          = row_ff + DIM_W'(1);
            if (row_ff == n_ff) begin
               state_in = SEQ_WAIT;
            end
         end
         SEQ_WAIT: begin
            if (done) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         tag_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tag_ff   <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      if (accept) begin
         n_ff <= (rows_n > MAX_N_DIM) ? MAX_N_DIM : rows_n;
         m_ff <= (cols_m > MAX_M_DIM) ? MAX_M_DIM : cols_m;
      end
   end

   assign busy    = (state_ff != SEQ_IDLE);
   assign col_sel = m_ff[COL_W-1:0];
   assign tag     = tag_ff;

   `ASSERT_CLK(a_row_bound, (state_ff != SEQ_ISSUE) || (row_ff <= n_ff), "row past n")
   `ASSERT_CLK(a_done_in_wait, !done || (state_ff == SEQ_WAIT), "result outside wait")
   `ASSERT_NEXT(a_accept_issue, accept, (state_ff == SEQ_ISSUE) && (row_ff == '0),
                "accept did not start row 0")

endmodule
